// File: src/nfa_sm_pkg.sv
// Package for the NFA set-simulation matcher.
// Holds the edge entry layout, action and register codes, and the sequencer states.
// No dependencies.
package nfa_sm_pkg;

  typedef struct packed {
    logic [5:0] src;
    logic [5:0] dst;
    logic       eps;
    logic [7:0] lo;
    logic [7:0] hi;
  } edge_t;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_BEGIN = 2'd1;
  localparam logic [1:0] ACT_CHAR  = 2'd2;

  localparam logic [1:0] REG_START      = 2'd0;
  localparam logic [1:0] REG_FINAL      = 2'd1;
  localparam logic [1:0] REG_EDGE_COUNT = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StClose,
    StFinish
  } state_e;

endpackage

// File: src/nfa_set_simulation_matcher.sv
// Top level of the NFA set-simulation matcher: edge table memory, active set and sequencer.
// Depends on nfa_sm_pkg.
//
// Load-edge items write one slot of the edge table, with no result.
// A begin item seeds the start state and runs epsilon-closure passes; a character item
// runs one walk over the table for the character edges, then closure passes until a pass
// adds no state; a walk that reaches no state marks the string dead and skips closure.
// Each pass reads one edge per cycle from the table memory, over the live edge count
// (edge_count, capped at NUM_EDGES). A character on a dead string skips the walk. One item
// is in work at a time; a result waits in the output register while the next item is
// already taken.
module nfa_set_simulation_matcher
  import nfa_sm_pkg::*;
#(
  parameter int NUM_STATES = 64,
  parameter int NUM_EDGES  = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [6:0] edge_index_i,
  input  logic [5:0] edge_source_i,
  input  logic [5:0] edge_target_i,
  input  logic       edge_is_epsilon_i,
  input  logic [7:0] range_low_i,
  input  logic [7:0] range_high_i,
  input  logic [7:0] character_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       accepted_o,
  output logic       alive_o
);

  localparam int AW = (NUM_EDGES > 1) ? $clog2(NUM_EDGES) : 1;
  localparam int CW = $clog2(NUM_EDGES + 1);
  localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int PW = (SW > 6) ? SW : 6;
  localparam int EW = $bits(edge_t);

  state_e state_q, state_d;

  logic [5:0] start_q, final_q;
  logic [7:0] edge_count_q;

  logic [NUM_STATES-1:0] act_q, act_d;
  logic [NUM_STATES-1:0] nxt_q, nxt_d;
  logic any_q, any_d;
  logic chg_q, chg_d;
  logic dead_q, dead_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic rd_vld_q, rd_vld_d;
  logic [7:0] char_q, char_d;
  logic out_valid_q, out_valid_d;
  logic acc_q, acc_d;
  logic alive_q, alive_d;

  logic [EW-1:0] edge_mem_q [NUM_EDGES];
  logic [EW-1:0] rd_data_q;
  logic          rd_en;
  logic          mem_we;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  edge_t         wr_edge;
  edge_t         rd_edge;

  logic [CW-1:0] live;
  logic          idx_ok;
  logic [PW-1:0] src_w, dst_w, start_w, fin_w;
  logic          src_ok, dst_ok, start_ok, fin_ok;
  logic [SW-1:0] src_idx, dst_idx, start_idx, fin_idx;
  logic          src_has, walk_hit, eps_hit, fin_hit;
  logic          pass_end;

  // Config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q      <= '0;
      final_q      <= '0;
      edge_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_START:      start_q      <= cfg_data_i[5:0];
        REG_FINAL:      final_q      <= cfg_data_i[5:0];
        REG_EDGE_COUNT: edge_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign live = (32'(edge_count_q) > 32'(NUM_EDGES)) ? CW'(NUM_EDGES) : CW'(edge_count_q);

  // Edge table
  assign idx_ok  = 32'(edge_index_i) < 32'(NUM_EDGES);
  assign wr_addr = AW'(edge_index_i);
  assign rd_addr = cnt_q[AW-1:0];
  assign wr_edge = '{src: edge_source_i, dst: edge_target_i, eps: edge_is_epsilon_i,
                     lo: range_low_i, hi: range_high_i};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      edge_mem_q[wr_addr] <= wr_edge;
    end
    if (rd_en) begin
      rd_data_q <= edge_mem_q[rd_addr];
    end
  end

  assign rd_edge = edge_t'(rd_data_q);

  // State lookups
  assign src_w     = PW'(rd_edge.src);
  assign dst_w     = PW'(rd_edge.dst);
  assign start_w   = PW'(start_q);
  assign fin_w     = PW'(final_q);
  assign src_ok    = 32'(src_w) < 32'(NUM_STATES);
  assign dst_ok    = 32'(dst_w) < 32'(NUM_STATES);
  assign start_ok  = 32'(start_w) < 32'(NUM_STATES);
  assign fin_ok    = 32'(fin_w) < 32'(NUM_STATES);
  assign src_idx   = src_w[SW-1:0];
  assign dst_idx   = dst_w[SW-1:0];
  assign start_idx = start_w[SW-1:0];
  assign fin_idx   = fin_w[SW-1:0];

  assign src_has  = src_ok && act_q[src_idx];
  assign walk_hit = !rd_edge.eps && (char_q >= rd_edge.lo) && (char_q <= rd_edge.hi)
                    && src_has && dst_ok;
  assign eps_hit  = rd_edge.eps && src_has && dst_ok && !act_q[dst_idx];
  assign fin_hit  = fin_ok && act_q[fin_idx];
  assign pass_end = (cnt_q == live) && !rd_vld_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    nxt_d       = nxt_q;
    any_d       = any_q;
    chg_d       = chg_q;
    dead_d      = dead_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_en       = 1'b0;
    char_d      = char_q;
    out_valid_d = out_valid_q;
    acc_d       = acc_q;
    alive_d     = alive_q;
    mem_we      = 1'b0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (action_i)
            ACT_LOAD: begin
              mem_we = idx_ok;
            end
            ACT_BEGIN: begin
              act_d = '0;
              if (start_ok) begin
                act_d[start_idx] = 1'b1;
              end
              dead_d  = 1'b0;
              cnt_d   = '0;
              chg_d   = 1'b0;
              state_d = StClose;
            end
            ACT_CHAR: begin
              char_d = character_i;
              if (dead_q) begin
                state_d = StFinish;
              end else begin
                nxt_d   = '0;
                any_d   = 1'b0;
                cnt_d   = '0;
                state_d = StWalk;
              end
            end
            default: ;
          endcase
        end
      end

      StWalk: begin
        if (cnt_q < live) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q + CW'(1);
        end
        if (rd_vld_q && walk_hit) begin
          nxt_d[dst_idx] = 1'b1;
          any_d          = 1'b1;
        end
        if (pass_end) begin
          if (!any_q) begin
            dead_d  = 1'b1;
            act_d   = '0;
            state_d = StFinish;
          end else begin
            act_d   = nxt_q;
            cnt_d   = '0;
            chg_d   = 1'b0;
            state_d = StClose;
          end
        end
      end

      StClose: begin
        if (cnt_q < live) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q + CW'(1);
        end
        if (rd_vld_q && eps_hit) begin
          act_d[dst_idx] = 1'b1;
          chg_d          = 1'b1;
        end
        if (pass_end) begin
          if (chg_q) begin
            cnt_d = '0;
            chg_d = 1'b0;
          end else begin
            state_d = StFinish;
          end
        end
      end

      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          acc_d       = !dead_q && fin_hit;
          alive_d     = !dead_q;
          state_d     = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      act_q       <= '0;
      nxt_q       <= '0;
      any_q       <= 1'b0;
      chg_q       <= 1'b0;
      dead_q      <= 1'b0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      nxt_q       <= nxt_d;
      any_q       <= any_d;
      chg_q       <= chg_d;
      dead_q      <= dead_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q  <= char_d;
    acc_q   <= acc_d;
    alive_q <= alive_d;
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = acc_q;
  assign alive_o     = alive_q;

  // Checks
  a_rd_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == StWalk || state_q == StClose))
    else $error("edge read returned outside a table pass");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk || state_q == StClose) |-> (cnt_q <= live))
    else $error("edge counter ran past the live edge count");

  a_dead_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dead_q |-> (act_q == '0))
    else $error("dead string with active states");

  a_walk_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> !dead_q)
    else $error("character walk on a dead string");

endmodule
